// ----- design/u16w8_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the byte-encoding function for the UTF-16 to WTF-8 encoder.
// No dependencies; used by every module of the block.
package u16w8_pkg;

    localparam int UNIT_W          = 16;
    localparam int BYTE_W          = 8;
    localparam int CP_W            = 21;
    localparam int HB_W            = 10;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hD800;
    localparam logic [UNIT_W-1:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hDC00;
    localparam logic [UNIT_W-1:0] LOW_LAST   = 16'hDFFF;
    localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h10000;

    // Byte count minus one of an encoded code point
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    // One code point waiting to be serialized
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic [1:0]      len_m1;
        logic            run_end;
        logic            string_end;
    } t_entry;

    // Byte idx (0 = lead byte) of code point cp encoded in len_m1+1 bytes
    function automatic logic [BYTE_W-1:0] enc_byte(input logic [CP_W-1:0] cp,
                                                  input logic [1:0] len_m1,
                                                  input logic [1:0] idx);
        logic [1:0]       pos;
        logic [5:0]       six;
        logic [BYTE_W-1:0] lead;
        pos = len_m1 - idx;
        case (pos)
            2'd0:    six = cp[5:0];
            2'd1:    six = cp[11:6];
            2'd2:    six = cp[17:12];
            default: six = {3'b000, cp[20:18]};
        endcase
        case (len_m1)
            LEN_1:   lead = {1'b0, cp[6:0]};
            LEN_2:   lead = {3'b110, cp[10:6]};
            LEN_3:   lead = {4'b1110, cp[15:12]};
            default: lead = {5'b11110, cp[20:18]};
        endcase
        return (idx == 2'd0) ? lead : {2'b10, six};
    endfunction

endpackage

// ----- design/u16w8_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts UTF-16 units, pairs surrogates and pushes code points to the queue.
// Depends on u16w8_pkg.
module u16w8_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [u16w8_pkg::UNIT_W-1:0] i_unit,
    input  logic                         i_final,
    output logic                         o_push,
    output u16w8_pkg::t_entry            o_push_data,
    input  logic                         i_full
);
    import u16w8_pkg::*;

    logic            r_hp, n_hp;
    logic [HB_W-1:0] r_hb, n_hb;
    logic            r_sv, n_sv;
    t_entry          r_se, n_se;

    logic   accept, is_high, is_low, push;
    t_entry e_unit, e_lone, e_pair, push_data;

    assign is_high = (i_unit >= HIGH_FIRST) && (i_unit <= HIGH_LAST);
    assign is_low  = (i_unit >= LOW_FIRST) && (i_unit <= LOW_LAST);
    assign accept  = i_valid && !r_sv && !i_full;

    always_comb begin
        e_unit.cp         = {{(CP_W-UNIT_W){1'b0}}, i_unit};
        e_unit.len_m1     = (i_unit < 16'h0080) ? LEN_1 : (i_unit < 16'h0800) ? LEN_2 : LEN_3;
        e_unit.run_end    = 1'b1;
        e_unit.string_end = i_final;

        e_lone.cp         = {5'b00000, 6'b110110, r_hb};
        e_lone.len_m1     = LEN_3;
        e_lone.run_end    = 1'b0;
        e_lone.string_end = 1'b0;

        e_pair.cp         = {1'b0, r_hb, i_unit[HB_W-1:0]} + SUPP_BASE;
        e_pair.len_m1     = LEN_4;
        e_pair.run_end    = 1'b1;
        e_pair.string_end = i_final;
    end

    always_comb begin
        n_hp      = r_hp;
        n_hb      = r_hb;
        n_sv      = r_sv;
        n_se      = r_se;
        push      = 1'b0;
        push_data = r_se;
        if (r_sv) begin
            // drain the second code point of the previous unit
            if (!i_full) begin
                push = 1'b1;
                n_sv = 1'b0;
            end
        end else if (accept) begin
            if (r_hp) begin
                n_hp = 1'b0;
                n_hb = '0;
                push = 1'b1;
                if (is_low) begin
                    push_data = e_pair;
                end else begin
                    push_data = e_lone;
                    if (is_high && !i_final) begin
                        n_hp              = 1'b1;
                        n_hb              = i_unit[HB_W-1:0];
                        push_data.run_end = 1'b1;
                    end else begin
                        n_sv = 1'b1;
                        n_se = e_unit;
                    end
                end
            end else if (is_high && !i_final) begin
                n_hp = 1'b1;
                n_hb = i_unit[HB_W-1:0];
            end else begin
                push      = 1'b1;
                push_data = e_unit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp <= 1'b0;
            r_hb <= '0;
            r_sv <= 1'b0;
        end else begin
            r_hp <= n_hp;
            r_hb <= n_hb;
            r_sv <= n_sv;
        end
        r_se <= n_se;
    end

    assign o_ready     = !r_sv && !i_full;
    assign o_push      = push;
    assign o_push_data = push_data;

    a_second_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> !o_ready)
        else $error("front takes a unit while a second code point is pending");
    a_second_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_se.run_end && !r_hp)
        else $error("pending second code point must close its run with nothing held");
    a_hold_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_hp && is_high && !i_final) |-> !o_push)
        else $error("held high surrogate must not push a code point");

endmodule

// ----- design/u16w8_fifo.sv -----
`timescale 1ns / 1ps
// Short queue of code-point entries between the front and back ends.
// Depends on u16w8_pkg.
module u16w8_fifo #(
    parameter int DEPTH = u16w8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u16w8_pkg::t_entry i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output u16w8_pkg::t_entry o_pop_data,
    output logic              o_empty
);
    import u16w8_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_full     = (r_cnt == FULL_CNT);
    assign o_empty    = (r_cnt == '0);
    assign o_pop_data = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("queue count beyond depth");

endmodule

// ----- design/u16w8_back.sv -----
`timescale 1ns / 1ps
// Back end: pops code points and serializes their WTF-8 bytes into an output register.
// Depends on u16w8_pkg.
module u16w8_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  u16w8_pkg::t_entry            i_pop_data,
    input  logic                         i_empty,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [u16w8_pkg::BYTE_W-1:0] o_byte,
    output logic                         o_run_end,
    output logic                         o_string_end
);
    import u16w8_pkg::*;

    logic              r_busy, n_busy;
    t_entry            r_ent, n_ent;
    logic [1:0]        r_idx, n_idx;
    logic              r_ovalid, n_ovalid;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_orun, n_orun;
    logic              r_ostr, n_ostr;

    logic slot_free, last_byte, pop;

    assign slot_free = !r_ovalid || i_ready;
    assign last_byte = (r_idx == r_ent.len_m1);

    always_comb begin
        n_busy   = r_busy;
        n_ent    = r_ent;
        n_idx    = r_idx;
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_orun   = r_orun;
        n_ostr   = r_ostr;
        pop      = 1'b0;
        if (slot_free) begin
            n_ovalid = r_busy;
            if (r_busy) begin
                n_obyte = enc_byte(r_ent.cp, r_ent.len_m1, r_idx);
                n_orun  = r_ent.run_end && last_byte;
                n_ostr  = r_ent.string_end && last_byte;
                if (last_byte) begin
                    // chain straight into the next code point when one waits
                    pop    = !i_empty;
                    n_busy = !i_empty;
                    n_ent  = i_pop_data;
                    n_idx  = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
        end
        if (!r_busy && !i_empty) begin
            pop    = 1'b1;
            n_busy = 1'b1;
            n_ent  = i_pop_data;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
        r_ent   <= n_ent;
        r_obyte <= n_obyte;
        r_orun  <= n_orun;
        r_ostr  <= n_ostr;
    end

    assign o_pop        = pop;
    assign o_valid      = r_ovalid;
    assign o_byte       = r_obyte;
    assign o_run_end    = r_orun;
    assign o_string_end = r_ostr;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= r_ent.len_m1)
        else $error("byte index past code point length");
    a_string_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostr) |-> r_orun)
        else $error("string end without run end");
    a_pop_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_busy || (slot_free && last_byte)))
        else $error("pop while current code point still serializing");

endmodule

// ----- design/utf16_to_wtf8_encoder.sv -----
`timescale 1ns / 1ps
// Top level of the UTF-16 to WTF-8 encoder: front end, code-point queue, back end.
// Depends on u16w8_pkg, u16w8_front, u16w8_fifo and u16w8_back.
//
// Usage:
//   Slave stream: one UTF-16 code unit per request in tdata, tlast set on the
//   last unit of a string. Master stream: one WTF-8 byte per request in
//   tdata, tuser[0] set on the last byte caused by an input unit, tlast set
//   on the last byte of the string.
//   A high surrogate that is not the last unit is held and produces nothing
//   until the next unit shows whether it pairs with a low surrogate; a pair
//   leaves as one four-byte code point, anything else releases the held unit
//   as a three-byte lone surrogate ahead of the new unit's bytes.
//   With the queue empty, a unit's first byte passes through the queue, the
//   back end's code-point register and the output register. The back end sends
//   one byte per cycle while the receiver is ready, so a unit yields 1 to 3
//   bytes (a surrogate pair 4 for two units, a held high plus a non-low unit up
//   to 6); the single-byte output port sets that rate. The front takes one unit
//   per cycle while the queue has room, but pauses after it releases a held
//   high ahead of a unit with bytes of its own, to push that unit's code point.
//   Reset (i_rst_n low, synchronous) empties the queue and the output
//   register and drops any held surrogate. When the receiver stalls, the
//   output byte holds, the queue fills and then tready on the slave side
//   drops until bytes drain.
module utf16_to_wtf8_encoder #(
    parameter int QUEUE_DEPTH = u16w8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [u16w8_pkg::UNIT_W-1:0] i_s_tdata,  // [15:0] code_unit
    input  logic                         i_s_tlast,  // final_unit
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [u16w8_pkg::BYTE_W-1:0] o_m_tdata,  // [7:0] out_byte
    output logic [0:0]                   o_m_tuser,  // [0] run_end
    output logic                         o_m_tlast   // string_end
);
    import u16w8_pkg::*;

    logic   push, full, pop, empty, run_end;
    t_entry push_data, pop_data;

    // Front: classify units and pair surrogates
    u16w8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_unit      (i_s_tdata),
        .i_final     (i_s_tlast),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    // Queue decouples unit acceptance from byte output
    u16w8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (empty)
    );

    // Back: serialize code points into bytes
    u16w8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_data   (pop_data),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_byte       (o_m_tdata),
        .o_run_end    (run_end),
        .o_string_end (o_m_tlast)
    );

    assign o_m_tuser = run_end;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for utf16_to_wtf8_encoder: streams UTF-16 strings in and
// checks every WTF-8 byte against a built-in transcoder model. Depends on u16w8_pkg.
module tb;
    import u16w8_pkg::*;

    localparam int IDLE_PCT    = 24;
    localparam int RANDOM_UNITS = 480;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SHOWN_ERRORS = 10;

    // One UTF-16 code unit waiting to be sent, with its end-of-string mark
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              ends_string;
    } utf16_unit_t;

    // One WTF-8 byte as it should leave the block
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_end;
        logic              string_end;
    } wtf8_byte_t;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [UNIT_W-1:0] i_s_tdata  = '0;  // [15:0] code_unit
    logic              i_s_tlast  = 1'b0; // final_unit
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [BYTE_W-1:0] o_m_tdata;        // [7:0] out_byte
    logic [0:0]        o_m_tuser;        // [0] run_end
    logic              o_m_tlast;        // string_end

    utf16_unit_t       unit_queue[$];     // units not yet offered to the block
    wtf8_byte_t        wtf8_expected[$];  // bytes predicted but not yet seen
    logic [BYTE_W-1:0] run_bytes[$];      // scratch: bytes of the current request

    // Surrogate the model is holding, mirrors what the block should hold
    logic              high_held = 1'b0;
    logic [HB_W-1:0]   held_bits = '0;

    int units_taken  = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;

    // Stretch of the run with no idling on either side
    wire calm = (units_taken >= 200) && (units_taken < 300);

    utf16_to_wtf8_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Append the UTF-8 style bytes of one code point to the current run
    function automatic void append_point(input logic [CP_W-1:0] cp);
        if (cp < 21'h80) begin
            run_bytes.push_back({1'b0, cp[6:0]});
        end else if (cp < 21'h800) begin
            run_bytes.push_back({3'b110, cp[10:6]});
            run_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < SUPP_BASE) begin
            run_bytes.push_back({4'b1110, cp[15:12]});
            run_bytes.push_back({2'b10, cp[11:6]});
            run_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            run_bytes.push_back({5'b11110, cp[20:18]});
            run_bytes.push_back({2'b10, cp[17:12]});
            run_bytes.push_back({2'b10, cp[11:6]});
            run_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    // Work out the bytes one accepted unit causes and queue them as expected
    function automatic void transcode_unit(input logic [UNIT_W-1:0] unit,
                                           input logic ends_string);
        logic is_high;
        logic is_low;
        logic paired;
        is_high = (unit >= HIGH_FIRST) && (unit <= HIGH_LAST);
        is_low  = (unit >= LOW_FIRST) && (unit <= LOW_LAST);
        paired  = 1'b0;
        run_bytes.delete();

        // A held high either pairs with this low or goes out alone first
        if (high_held) begin
            if (is_low) begin
                append_point(SUPP_BASE + {1'b0, held_bits, unit[HB_W-1:0]});
                paired = 1'b1;
            end else begin
                append_point(CP_W'(HIGH_FIRST | {6'b0, held_bits}));
            end
            high_held = 1'b0;
            held_bits = '0;
        end

        // Hold a high unless it ends the string; everything else goes out now
        if (!paired) begin
            if (is_high && !ends_string) begin
                high_held = 1'b1;
                held_bits = unit[HB_W-1:0];
            end else begin
                append_point(CP_W'(unit));
            end
        end

        foreach (run_bytes[i]) begin
            wtf8_expected.push_back({run_bytes[i], i == run_bytes.size() - 1,
                                     (i == run_bytes.size() - 1) && ends_string});
        end
    endfunction

    function automatic void add_unit(input logic [UNIT_W-1:0] unit,
                                     input logic ends_string);
        unit_queue.push_back({unit, ends_string});
    endfunction

    // Driver: advance to the next unit once the current request is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (unit_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_s_tdata  <= unit_queue[0].unit;
                i_s_tlast  <= unit_queue[0].ends_string;
                i_s_tvalid <= 1'b1;
                void'(unit_queue.pop_front());
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random outside the calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: predict on every accepted unit, check every accepted byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            high_held = 1'b0;
            held_bits = '0;
            quiet_cycles <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                transcode_unit(i_s_tdata, i_s_tlast);
                units_taken <= units_taken + 1;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (wtf8_expected.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < SHOWN_ERRORS)
                        $display("%0t: unexpected byte %02h run_end %b string_end %b",
                                 $time, o_m_tdata, o_m_tuser[0], o_m_tlast);
                end else begin
                    if (o_m_tdata !== wtf8_expected[0].data ||
                        o_m_tuser[0] !== wtf8_expected[0].run_end ||
                        o_m_tlast !== wtf8_expected[0].string_end) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < SHOWN_ERRORS)
                            $display({"%0t: byte mismatch, expected %02h/%b/%b",
                                      " got %02h/%b/%b (data/run_end/string_end)"},
                                     $time, wtf8_expected[0].data,
                                     wtf8_expected[0].run_end, wtf8_expected[0].string_end,
                                     o_m_tdata, o_m_tuser[0], o_m_tlast);
                    end
                    void'(wtf8_expected.pop_front());
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: end the run if traffic stops on both sides
    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int pieces;
        int kind;
        logic [UNIT_W-1:0] hi;

        // Directed: encoding-length boundaries
        add_unit(16'h0000, 1'b0);
        add_unit(16'h007F, 1'b0);
        add_unit(16'h0080, 1'b0);
        add_unit(16'h07FF, 1'b0);
        add_unit(16'h0800, 1'b0);
        add_unit(16'hD7FF, 1'b0);
        add_unit(16'hE000, 1'b0);
        add_unit(16'hFFFF, 1'b1);
        // well-formed pairs at the range edges, the second ending the string
        add_unit(HIGH_FIRST, 1'b0);
        add_unit(LOW_FIRST, 1'b0);
        add_unit(HIGH_LAST, 1'b0);
        add_unit(LOW_LAST, 1'b1);
        // lone low surrogates, one of them last
        add_unit(LOW_FIRST, 1'b0);
        add_unit(LOW_LAST, 1'b1);
        // high surrogate that ends the string goes out alone
        add_unit(HIGH_FIRST, 1'b1);
        // held high released by an ordinary unit
        add_unit(HIGH_LAST, 1'b0);
        add_unit(16'h0041, 1'b0);
        // held high followed by a final high: six bytes in one request
        add_unit(HIGH_FIRST, 1'b0);
        add_unit(HIGH_LAST, 1'b1);
        // held high replaced by another high that then pairs
        add_unit(16'hDA12, 1'b0);
        add_unit(16'hD9AB, 1'b0);
        add_unit(16'hDE34, 1'b1);
        // held high released by a final ordinary unit
        add_unit(16'hDB00, 1'b0);
        add_unit(16'h20AC, 1'b1);

        // Random strings, mostly well-formed, with lone surrogates and raw noise
        while (unit_queue.size() < RANDOM_UNITS + 24) begin
            pieces = $urandom_range(1, 8);
            for (int p = 0; p < pieces; p++) begin
                kind = $urandom_range(0, 99);
                if (kind < 25) begin
                    add_unit(UNIT_W'($urandom_range(0, 'h7F)), 1'b0);
                end else if (kind < 40) begin
                    add_unit(UNIT_W'($urandom_range('h80, 'h7FF)), 1'b0);
                end else if (kind < 55) begin
                    add_unit(UNIT_W'($urandom_range('h800, 'hD7FF)), 1'b0);
                end else if (kind < 60) begin
                    add_unit(UNIT_W'($urandom_range('hE000, 'hFFFF)), 1'b0);
                end else if (kind < 85) begin
                    hi = UNIT_W'($urandom_range(HIGH_FIRST, HIGH_LAST));
                    add_unit(hi, 1'b0);
                    add_unit(UNIT_W'($urandom_range(LOW_FIRST, LOW_LAST)), 1'b0);
                end else if (kind < 90) begin
                    add_unit(UNIT_W'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b0);
                end else if (kind < 94) begin
                    add_unit(UNIT_W'($urandom_range(LOW_FIRST, LOW_LAST)), 1'b0);
                end else begin
                    add_unit(UNIT_W'($urandom_range(0, 'hFFFF)), 1'b0);
                end
            end
            // mark the last unit of the string
            unit_queue[unit_queue.size() - 1].ends_string = 1'b1;
        end

        // Hold reset while the clock runs, then release it for good
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all units taken, all predicted bytes seen, then a short tail
        while (unit_queue.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (wtf8_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && wtf8_expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/u16w8_pkg.sv
design/u16w8_front.sv
design/u16w8_fifo.sv
design/u16w8_back.sv
design/utf16_to_wtf8_encoder.sv
test/tb.sv
